// File: rtl/core/ppmi_pkg.sv
// shared types and constants of the point projection max intensity image block
// no dependencies

package ppmi_pkg;

    localparam int IMG_W_DEF = 512;
    localparam int IMG_H_DEF = 512;

    // step counter width, holds the step index of each sequencer phase (transform, projection, divide)
    localparam int CNT_W = 4;

    localparam int REM_W = 66;
    localparam int CAM_W = 42;
    localparam int NUM_W = 64;
    localparam int MUL_W = 26;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_PROJECT = 2'd1;

    localparam logic [2:0] REG_ROW_X    = 3'd0;
    localparam logic [2:0] REG_ROW_Y    = 3'd1;
    localparam logic [2:0] REG_ROW_Z    = 3'd2;
    localparam logic [2:0] REG_FOCAL_X  = 3'd3;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd4;
    localparam logic [2:0] REG_CENTER_X = 3'd5;
    localparam logic [2:0] REG_CENTER_Y = 3'd6;
    localparam logic [2:0] REG_MIN_DEPTH = 3'd7;

    typedef enum logic [2:0] {
        STAT_WRITTEN = 3'd0,
        STAT_KEPT    = 3'd1,
        STAT_INVALID = 3'd2,
        STAT_NEAR    = 3'd3,
        STAT_OFF     = 3'd4,
        STAT_READ    = 3'd5,
        STAT_CLEARED = 3'd6
    } stat_e;

    typedef struct packed {
        logic [63:0] row_x;
        logic [63:0] row_y;
        logic [63:0] row_z;
        logic [19:0] focal_x;
        logic [19:0] focal_y;
        logic [19:0] center_x;
        logic [19:0] center_y;
        logic [22:0] min_depth;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic             xform;
        logic             proj;
        logic             mul;
        logic             acc;
        logic             div_init;
        logic             div_step;
        logic             div_fin;
        logic             axis;
        logic             clr;
        logic             mem_rd;
        logic             mem_wr;
        logic             res_load;
        stat_e            res_status;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic too_near;
        logic off_image;
        logic larger;
        logic clr_last;
    } sts_t;

endpackage

// File: rtl/core/ppmi_datapath.sv
// datapath: shared multiplier, transform and projection accumulators,
// bit-per-cycle divider, intensity store and result registers
// depends on ppmi_pkg

module ppmi_datapath
    import ppmi_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMG_W_DEF,
    parameter int IMAGE_HEIGHT = IMG_H_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  cfg_t               cfg,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    input  logic [15:0]        point_intensity,
    input  logic [8:0]         read_col,
    input  logic [8:0]         read_row,
    output logic [2:0]         status,
    output logic [8:0]         pixel_col,
    output logic [8:0]         pixel_row,
    output logic [15:0]        pixel_value
);

    localparam int MAXD  = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int QW    = $clog2(MAXD);
    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMPW  = (QW + 1 > 10) ? QW + 1 : 10;

    logic signed [23:0]      px_reg, py_reg, pz_reg;
    logic [15:0]             inten_reg;
    logic [8:0]              rcol_reg, rrow_reg;
    logic                    rd_in_reg;
    logic signed [CAM_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [NUM_W-1:0] num_u_reg, num_v_reg;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic [CNT_W-1:0]        dst_reg;
    logic [REM_W-1:0]        rem_reg, dsh_reg;
    logic [QW-1:0]           q_reg, u_reg, v_reg;
    logic                    neg_reg, ovf_reg, off_reg;
    logic [AW-1:0]           clr_cnt_reg;
    logic [15:0]             rd_data_reg;
    logic [15:0]             mem_q [0:DEPTH-1];

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [15:0]      coef;
    logic signed [23:0]      pt;
    logic [19:0]             fac;
    logic signed [CAM_W-1:0] src;
    logic signed [NUM_W-1:0] pterm, n_sel;
    logic [NUM_W-1:0]        mag;
    logic [REM_W-1:0]        zc_ext, rem_init;
    logic [AW-1:0]           addr;
    logic [QW:0]             lim;
    logic                    bad;

    // multiplier operand select
    always_comb
    begin
        coef = '0;
        pt   = '0;
        unique case (cmd.cnt)
            4'd0: begin coef = cfg.row_x[63:48]; pt = px_reg; end
            4'd1: begin coef = cfg.row_x[47:32]; pt = py_reg; end
            4'd2: begin coef = cfg.row_x[31:16]; pt = pz_reg; end
            4'd3: begin coef = cfg.row_y[63:48]; pt = px_reg; end
            4'd4: begin coef = cfg.row_y[47:32]; pt = py_reg; end
            4'd5: begin coef = cfg.row_y[31:16]; pt = pz_reg; end
            4'd6: begin coef = cfg.row_z[63:48]; pt = px_reg; end
            4'd7: begin coef = cfg.row_z[47:32]; pt = py_reg; end
            4'd8: begin coef = cfg.row_z[31:16]; pt = pz_reg; end
            default: begin coef = '0; pt = '0; end
        endcase
        // projection terms: bit2 axis, bit1 center term, bit0 low half
        if (cmd.cnt[1])
        begin
            fac = cmd.cnt[2] ? cfg.center_y : cfg.center_x;
            src = cam_z_reg;
        end
        else
        begin
            fac = cmd.cnt[2] ? cfg.focal_y : cfg.focal_x;
            src = cmd.cnt[2] ? cam_y_reg : cam_x_reg;
        end
        if (cmd.xform)
        begin
            mul_a = MUL_W'(coef);
            mul_b = MUL_W'(pt);
        end
        else
        begin
            mul_a = MUL_W'(signed'({1'b0, fac}));
            // high half carries the sign, low half is a plain magnitude
            mul_b = cmd.cnt[0] ? MUL_W'(signed'({1'b0, src[20:0]}))
                               : MUL_W'(signed'(src[CAM_W-1:21]));
        end
    end

    always_comb
    begin
        pterm = NUM_W'(prod_reg);
        if (!dst_reg[0])
            pterm = pterm <<< 21;
    end

    // divider setup: quotient of (2|n| + 16z) by 32z
    always_comb
    begin
        n_sel    = cmd.axis ? num_v_reg : num_u_reg;
        mag      = n_sel[NUM_W-1] ? NUM_W'(-n_sel) : NUM_W'(n_sel);
        zc_ext   = REM_W'(cam_z_reg);
        rem_init = (REM_W'(mag) << 1) + (zc_ext << 4);
        lim      = cmd.axis ? (QW+1)'(IMAGE_HEIGHT) : (QW+1)'(IMAGE_WIDTH);
        bad      = ovf_reg || (neg_reg && (q_reg != '0)) || !((QW+1)'(q_reg) < lim);
    end

    assign addr = AW'(v_reg) * AW'(IMAGE_WIDTH) + AW'(u_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg    <= point_x;
            py_reg    <= point_y;
            pz_reg    <= point_z;
            inten_reg <= point_intensity;
            rcol_reg  <= read_col;
            rrow_reg  <= read_row;
            rd_in_reg <= (CMPW'(read_col) < CMPW'(IMAGE_WIDTH))
                      && (CMPW'(read_row) < CMPW'(IMAGE_HEIGHT));
            u_reg     <= QW'(read_col);
            v_reg     <= QW'(read_row);
            cam_x_reg <= CAM_W'(signed'(cfg.row_x[15:0])) <<< 14;
            cam_y_reg <= CAM_W'(signed'(cfg.row_y[15:0])) <<< 14;
            cam_z_reg <= CAM_W'(signed'(cfg.row_z[15:0])) <<< 14;
            num_u_reg <= '0;
            num_v_reg <= '0;
            off_reg   <= 1'b0;
        end
        if (cmd.mul)
        begin
            prod_reg <= mul_a * mul_b;
            dst_reg  <= cmd.cnt;
        end
        if (cmd.acc && cmd.xform)
        begin
            if (dst_reg < 4'd3)
                cam_x_reg <= cam_x_reg + signed'(prod_reg[CAM_W-1:0]);
            else if (dst_reg < 4'd6)
                cam_y_reg <= cam_y_reg + signed'(prod_reg[CAM_W-1:0]);
            else
                cam_z_reg <= cam_z_reg + signed'(prod_reg[CAM_W-1:0]);
        end
        if (cmd.acc && cmd.proj)
        begin
            if (dst_reg[2])
                num_v_reg <= num_v_reg + pterm;
            else
                num_u_reg <= num_u_reg + pterm;
        end
        if (cmd.div_init)
        begin
            rem_reg <= rem_init;
            dsh_reg <= zc_ext << (5 + QW - 1);
            ovf_reg <= rem_init >= (zc_ext << (5 + QW));
            neg_reg <= n_sel[NUM_W-1];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
                q_reg <= {q_reg[QW-2:0], 1'b0};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_fin)
        begin
            off_reg <= off_reg | bad;
            if (cmd.axis)
                v_reg <= q_reg;
            else
                u_reg <= q_reg;
        end
        if (cmd.res_load)
        begin
            status <= cmd.res_status;
            unique case (cmd.res_status)
                STAT_WRITTEN:
                begin
                    pixel_col   <= 9'(u_reg);
                    pixel_row   <= 9'(v_reg);
                    pixel_value <= inten_reg;
                end
                STAT_KEPT:
                begin
                    pixel_col   <= 9'(u_reg);
                    pixel_row   <= 9'(v_reg);
                    pixel_value <= rd_data_reg;
                end
                STAT_READ:
                begin
                    pixel_col   <= rcol_reg;
                    pixel_row   <= rrow_reg;
                    pixel_value <= rd_in_reg ? rd_data_reg : 16'd0;
                end
                default:
                begin
                    pixel_col   <= '0;
                    pixel_row   <= '0;
                    pixel_value <= '0;
                end
            endcase
        end
    end

    // intensity store, one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
            mem_q[clr_cnt_reg] <= 16'd0;
        else if (cmd.mem_wr)
            mem_q[addr] <= inten_reg;
        if (cmd.mem_rd)
            rd_data_reg <= mem_q[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr)
            clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + 1'b1;
    end

    always_comb
    begin
        sts.too_near  = (cam_z_reg <= 0)
                     || (cam_z_reg < signed'({1'b0, cfg.min_depth, 14'b0}));
        sts.off_image = off_reg;
        sts.larger    = rd_data_reg < inten_reg;
        sts.clr_last  = clr_cnt_reg == AW'(DEPTH - 1);
    end

endmodule

// File: rtl/core/ppmi_ctrl.sv
// sequencer state machine: steps the datapath through clear, transform, projection,
// division, store access and result handoff; owns the handshake
// depends on ppmi_pkg

module ppmi_ctrl
    import ppmi_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMG_W_DEF,
    parameter int IMAGE_HEIGHT = IMG_H_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic       point_valid,
    output logic       out_valid,
    input  logic       out_ready,
    output cmd_t       cmd,
    input  sts_t       sts
);

    localparam int MAXD = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int QW   = $clog2(MAXD);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW + 1);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_XFORM  = 10'b0000000100,
        ST_CHECK  = 10'b0000001000,
        ST_PROJ   = 10'b0000010000,
        ST_DIV    = 10'b0000100000,
        ST_BOUND  = 10'b0001000000,
        ST_MEMRD  = 10'b0010000000,
        ST_UPDATE = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             axis_reg, axis_next;
    stat_e            stat_reg, stat_next;
    logic             is_read_reg, is_read_next;
    logic             clr_res_reg, clr_res_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        stat_next    = stat_reg;
        is_read_next = is_read_reg;
        clr_res_next = clr_res_reg;
        cmd          = '0;
        cmd.cnt      = cnt_reg;
        cmd.axis     = axis_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    stat_next  = STAT_CLEARED;
                    state_next = clr_res_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cnt_next     = '0;
                    axis_next    = 1'b0;
                    is_read_next = 1'b0;
                    if (action == ACT_CLEAR)
                    begin
                        clr_res_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    else if (action == ACT_PROJECT)
                    begin
                        if (point_valid)
                            state_next = ST_XFORM;
                        else
                        begin
                            stat_next  = STAT_INVALID;
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        is_read_next = 1'b1;
                        state_next   = ST_MEMRD;
                    end
                end
            end
            ST_XFORM:
            begin
                cmd.xform = 1'b1;
                cmd.mul   = (cnt_reg < 4'd9);
                cmd.acc   = (cnt_reg != '0);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 4'd9)
                begin
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.too_near)
                begin
                    stat_next  = STAT_NEAR;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.proj = 1'b1;
                cmd.mul  = (cnt_reg < 4'd8);
                cmd.acc  = (cnt_reg != '0);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd8)
                begin
                    cnt_next   = '0;
                    axis_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_init = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0) && (cnt_reg != DIV_LAST);
                cmd.div_fin  = (cnt_reg == DIV_LAST);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next  = '0;
                    axis_next = 1'b1;
                    if (axis_reg)
                        state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                if (sts.off_image)
                begin
                    stat_next  = STAT_OFF;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_MEMRD;
            end
            ST_MEMRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    if (is_read_reg)
                        cmd.res_status = STAT_READ;
                    else if (sts.larger)
                    begin
                        cmd.res_status = STAT_WRITTEN;
                        cmd.mem_wr     = 1'b1;
                    end
                    else
                        cmd.res_status = STAT_KEPT;
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = cmd.res_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            axis_reg      <= 1'b0;
            stat_reg      <= STAT_CLEARED;
            is_read_reg   <= 1'b0;
            clr_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            stat_reg      <= stat_next;
            is_read_reg   <= is_read_next;
            clr_res_reg   <= clr_res_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/point_projection_max_intensity_image.sv
// top level: configuration registers, sequencer and datapath
// depends on ppmi_pkg, ppmi_ctrl, ppmi_datapath
//
// usage
//   request channel (in_valid/in_ready) carries one action: clear the image,
//   project a point, or read a pixel. each request yields exactly one response
//   on the response channel (out_valid/out_ready) with status, pixel address
//   and pixel intensity.
//   a projected point runs through a shared 26x26 multiplier (nine transform
//   products, eight projection products) and a one-bit-per-cycle divider run
//   once per image axis. a read passes only through the store read and the
//   result handoff, and a rejected point goes to its response straight
//   from the check that rejects it. a clear sweeps the store one entry a cycle.
//   one request is in flight at a time; in_ready is high only when idle.
//   after reset the store is swept to zero the same way with in_ready low;
//   configuration writes are taken meanwhile.
//   a finished response sits in the output register; the next request is
//   still accepted and worked on, and it waits only for its own handoff
//   while the receiver stalls.
//   configuration writes are taken any cycle cfg_we is high, but only change
//   behavior safely while no request is in flight.

module point_projection_max_intensity_image
    import ppmi_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMG_W_DEF,
    parameter int IMAGE_HEIGHT = IMG_H_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    input  logic [15:0]        point_intensity,
    input  logic               point_valid,
    input  logic [8:0]         read_col,
    input  logic [8:0]         read_row,
    // response channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [8:0]         pixel_col,
    output logic [8:0]         pixel_row,
    output logic [15:0]        pixel_value,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers, reset to identity transform and a 500 pixel focal length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_x     <= 64'h4000_0000_0000_0000;
            cfg_reg.row_y     <= 64'h0000_4000_0000_0000;
            cfg_reg.row_z     <= 64'h0000_0000_4000_0000;
            cfg_reg.focal_x   <= 20'd8000;
            cfg_reg.focal_y   <= 20'd8000;
            cfg_reg.center_x  <= 20'd4096;
            cfg_reg.center_y  <= 20'd4096;
            cfg_reg.min_depth <= 23'd102;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_X:     cfg_reg.row_x     <= cfg_data;
                REG_ROW_Y:     cfg_reg.row_y     <= cfg_data;
                REG_ROW_Z:     cfg_reg.row_z     <= cfg_data;
                REG_FOCAL_X:   cfg_reg.focal_x   <= cfg_data[19:0];
                REG_FOCAL_Y:   cfg_reg.focal_y   <= cfg_data[19:0];
                REG_CENTER_X:  cfg_reg.center_x  <= cfg_data[19:0];
                REG_CENTER_Y:  cfg_reg.center_y  <= cfg_data[19:0];
                REG_MIN_DEPTH: cfg_reg.min_depth <= cfg_data[22:0];
                default:       cfg_reg.min_depth <= cfg_reg.min_depth;
            endcase
        end
    end

    // sequencer
    ppmi_ctrl #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .point_valid (point_valid),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    // arithmetic, store and response registers
    ppmi_datapath #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (cfg_reg),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .point_intensity (point_intensity),
        .read_col        (read_col),
        .read_row        (read_row),
        .status          (status),
        .pixel_col       (pixel_col),
        .pixel_row       (pixel_row),
        .pixel_value     (pixel_value)
    );

endmodule

// File: rtl/core/ppmi_checker.sv
// port-level checks of the point projection block, bound to the top level
// depends on ppmi_pkg and point_projection_max_intensity_image

module ppmi_checker
    import ppmi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [8:0]  pixel_col,
    input logic [8:0]  pixel_row,
    input logic [15:0] pixel_value
);

    // stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pixel_value))
        else $error("response changed while stalled");

    // one request at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // rejected points and clears carry zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_INVALID || status == STAT_NEAR
                      || status == STAT_OFF || status == STAT_CLEARED)
        |-> pixel_col == 9'd0 && pixel_row == 9'd0 && pixel_value == 16'd0)
        else $error("rejected response has nonzero fields");

    // a write only happens when the new intensity beats a stored value
    a_written_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_WRITTEN |-> pixel_value != 16'd0)
        else $error("written pixel holds zero");

endmodule

bind point_projection_max_intensity_image ppmi_checker u_ppmi_checker (.*);
